[rtl/glcd_pkg.sv]
package glcd_pkg;

  localparam int FONT_BYTES      = 4096;
  localparam int FONT_AW         = $clog2(FONT_BYTES);
  localparam int MAX_GLYPH_BYTES = 32;
  localparam int CNT_W           = $clog2(MAX_GLYPH_BYTES + 1);

  // glyph data starts after the font header
  localparam logic [FONT_AW-1:0] HEADER_BYTES = FONT_AW'(4);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_PARAM = 2'd1;
  localparam logic [1:0] KIND_PIX   = 2'd2;

  localparam logic [7:0] CMD_COL = 8'h2A;
  localparam logic [7:0] CMD_ROW = 8'h2B;
  localparam logic [7:0] CMD_MEM = 8'h2C;

  localparam logic [2:0] REG_FG_COLOR     = 3'd0;
  localparam logic [2:0] REG_BG_COLOR     = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_FIRST_CODE   = 3'd4;
  localparam logic [2:0] REG_SCREEN_X_MAX = 3'd5;
  localparam logic [2:0] REG_SCREEN_Y_MAX = 3'd6;

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [7:0]  first_code;
    logic [15:0] screen_x_max;
    logic [15:0] screen_y_max;
  } cfg_t;

endpackage

[rtl/glcd_font_ram.sv]
module glcd_font_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/glcd_seq.sv]
module glcd_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [7:0]                  char_code,
  input  logic [15:0]                 pos_x,
  input  logic [15:0]                 pos_y,
  input  glcd_pkg::cfg_t              cfg,
  output logic [glcd_pkg::FONT_AW-1:0] rd_addr,
  input  logic [7:0]                  rd_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  byte_value,
  output logic [7:0][15:0]            pixels,
  output logic                        last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN1 = 2'd1;
  localparam logic [1:0] ST_PIX  = 2'd2;
  localparam logic [1:0] ST_WIN2 = 2'd3;

  localparam logic [3:0] WIN_LAST = 4'd10;

  logic [1:0]                   state, state_next;
  logic [3:0]                   step, step_next;
  logic [glcd_pkg::CNT_W-1:0]   pix_cnt, pix_cnt_next;
  logic [glcd_pkg::CNT_W-1:0]   count;
  logic signed [8:0]            code_diff, code_diff_next;
  logic [15:0]                  x1, x1_next, y1, y1_next;
  logic [glcd_pkg::FONT_AW-1:0] addr, addr_next;

  logic                         out_valid_next;
  logic [1:0]                   kind_next;
  logic [7:0]                   byte_next;
  logic [7:0][15:0]             pixels_next;
  logic                         last_next;

  logic [8:0]                   count_raw;
  logic signed [15:0]           offset;
  logic [glcd_pkg::FONT_AW-1:0] start_addr;
  logic [15:0]                  wx1, wy1, wx2, wy2;
  logic [1:0]                   win_kind;
  logic [7:0]                   win_byte;
  logic                         load;

  // glyph bytes per character, saturated
  assign count_raw = 9'(cfg.glyph_width[5:3]) * 9'(cfg.glyph_height);

  always_ff @(posedge clk) begin
    if (count_raw > 9'(glcd_pkg::MAX_GLYPH_BYTES)) begin
      count <= glcd_pkg::CNT_W'(glcd_pkg::MAX_GLYPH_BYTES);
    end else begin
      count <= count_raw[glcd_pkg::CNT_W-1:0];
    end
  end

  // low address bits of a negative offset already give the wrapped address
  assign offset     = 16'(code_diff) * $signed({10'd0, count});
  assign start_addr = offset[glcd_pkg::FONT_AW-1:0] + glcd_pkg::HEADER_BYTES;

  assign load     = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);
  assign rd_addr  = addr_next;

  always_comb begin
    if (state == ST_WIN2) begin
      wx1 = '0;
      wy1 = '0;
      wx2 = cfg.screen_x_max;
      wy2 = cfg.screen_y_max;
    end else begin
      wx1 = x1;
      wy1 = y1;
      wx2 = x1 + 16'(cfg.glyph_width) - 16'd1;
      wy2 = y1 + 16'(cfg.glyph_height) - 16'd1;
    end
  end

  always_comb begin
    win_kind = glcd_pkg::KIND_PARAM;
    win_byte = '0;
    unique case (step)
      4'd0: begin
        win_kind = glcd_pkg::KIND_CMD;
        win_byte = glcd_pkg::CMD_COL;
      end
      4'd1: win_byte = wx1[15:8];
      4'd2: win_byte = wx1[7:0];
      4'd3: win_byte = wx2[15:8];
      4'd4: win_byte = wx2[7:0];
      4'd5: begin
        win_kind = glcd_pkg::KIND_CMD;
        win_byte = glcd_pkg::CMD_ROW;
      end
      4'd6: win_byte = wy1[15:8];
      4'd7: win_byte = wy1[7:0];
      4'd8: win_byte = wy2[15:8];
      4'd9: win_byte = wy2[7:0];
      4'd10: begin
        win_kind = glcd_pkg::KIND_CMD;
        win_byte = glcd_pkg::CMD_MEM;
      end
      default: begin
        win_kind = glcd_pkg::KIND_CMD;
        win_byte = '0;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    step_next      = step;
    pix_cnt_next   = pix_cnt;
    code_diff_next = code_diff;
    x1_next        = x1;
    y1_next        = y1;
    addr_next      = addr;
    out_valid_next = out_valid;
    kind_next      = kind;
    byte_next      = byte_value;
    pixels_next    = pixels;
    last_next      = last;

    if (load) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      ST_IDLE: begin
        if (in_valid && op == glcd_pkg::OP_DRAW) begin
          code_diff_next = $signed({1'b0, char_code}) - $signed({1'b0, cfg.first_code});
          x1_next        = pos_x;
          y1_next        = pos_y;
          step_next      = '0;
          state_next     = ST_WIN1;
        end
      end
      ST_WIN1: begin
        // keeps the read port on the first glyph byte
        addr_next = start_addr;
        if (load) begin
          out_valid_next = 1'b1;
          kind_next      = win_kind;
          byte_next      = win_byte;
          pixels_next    = '0;
          last_next      = 1'b0;
          if (step == WIN_LAST) begin
            step_next    = '0;
            pix_cnt_next = '0;
            state_next   = (count == '0) ? ST_WIN2 : ST_PIX;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      ST_PIX: begin
        if (load) begin
          out_valid_next = 1'b1;
          kind_next      = glcd_pkg::KIND_PIX;
          byte_next      = '0;
          last_next      = 1'b0;
          for (int b = 0; b < 8; b++) begin
            pixels_next[b] = rd_data[7-b] ? cfg.fg_color : cfg.bg_color;
          end
          addr_next    = addr + glcd_pkg::FONT_AW'(1);
          pix_cnt_next = pix_cnt + glcd_pkg::CNT_W'(1);
          if (pix_cnt == count - glcd_pkg::CNT_W'(1)) begin
            step_next  = '0;
            state_next = ST_WIN2;
          end
        end
      end
      ST_WIN2: begin
        if (load) begin
          out_valid_next = 1'b1;
          kind_next      = win_kind;
          byte_next      = win_byte;
          pixels_next    = '0;
          last_next      = (step == WIN_LAST);
          if (step == WIN_LAST) begin
            step_next  = '0;
            state_next = ST_IDLE;
          end else begin
            step_next = step + 4'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      pix_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      pix_cnt   <= pix_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    code_diff  <= code_diff_next;
    x1         <= x1_next;
    y1         <= y1_next;
    addr       <= addr_next;
    kind       <= kind_next;
    byte_value <= byte_next;
    pixels     <= pixels_next;
    last       <= last_next;
  end

endmodule

[rtl/glyph_to_lcd_pixel_stream_top.sv]
// Character generator for a serial TFT controller, RGB565 output. A load item (op 0) writes
// one glyph byte into the 4096-byte font store and leaves in_ready high. A draw item (op 1)
// sends the column/row/memory-write window for the character cell, then one result of eight
// pixels per glyph byte (MSB leftmost, fg_color for set bits, bg_color for clear), then the
// full-screen window; last marks its final command. A draw of B glyph bytes gives 22 + B
// results, one per cycle while out_ready stays high, and in_ready returns after the last
// of them is loaded into the output register; the pixel rate is set by the single read
// port of the font memory, which is read one address ahead. The user writes configuration
// through cfg_we/cfg_index/cfg_data while no draw is in progress; the block does not check.
module glyph_to_lcd_pixel_stream_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [11:0] font_addr,
  input  logic [7:0]  font_byte,
  input  logic [7:0]  char_code,
  input  logic [15:0] pos_x,
  input  logic [15:0] pos_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic [15:0] pixel0,
  output logic [15:0] pixel1,
  output logic [15:0] pixel2,
  output logic [15:0] pixel3,
  output logic [15:0] pixel4,
  output logic [15:0] pixel5,
  output logic [15:0] pixel6,
  output logic [15:0] pixel7,
  output logic        last
);

  glcd_pkg::cfg_t               cfg;
  logic [glcd_pkg::FONT_AW-1:0] rd_addr;
  logic [7:0]                   rd_data;
  logic [7:0][15:0]             pixels;
  logic                         font_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fg_color     <= 16'hFFFF;
      cfg.bg_color     <= 16'h0000;
      cfg.glyph_width  <= 6'd8;
      cfg.glyph_height <= 6'd12;
      cfg.first_code   <= 8'd32;
      cfg.screen_x_max <= 16'd239;
      cfg.screen_y_max <= 16'd319;
    end else if (cfg_we) begin
      unique case (cfg_index)
        glcd_pkg::REG_FG_COLOR:     cfg.fg_color     <= cfg_data;
        glcd_pkg::REG_BG_COLOR:     cfg.bg_color     <= cfg_data;
        glcd_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[5:0];
        glcd_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        glcd_pkg::REG_FIRST_CODE:   cfg.first_code   <= cfg_data[7:0];
        glcd_pkg::REG_SCREEN_X_MAX: cfg.screen_x_max <= cfg_data;
        glcd_pkg::REG_SCREEN_Y_MAX: cfg.screen_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // loads are taken only while no draw is running
  assign font_we = in_valid && in_ready && (op == glcd_pkg::OP_LOAD);

  glcd_font_ram #(
    .DEPTH(glcd_pkg::FONT_BYTES),
    .WIDTH(8)
  ) u_font_ram (
    .clk  (clk),
    .we   (font_we),
    .waddr(font_addr[glcd_pkg::FONT_AW-1:0]),
    .wdata(font_byte),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  glcd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .char_code (char_code),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cfg       (cfg),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .byte_value(byte_value),
    .pixels    (pixels),
    .last      (last)
  );

  assign pixel0 = pixels[0];
  assign pixel1 = pixels[1];
  assign pixel2 = pixels[2];
  assign pixel3 = pixels[3];
  assign pixel4 = pixels[4];
  assign pixel5 = pixels[5];
  assign pixel6 = pixels[6];
  assign pixel7 = pixels[7];

  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && op == glcd_pkg::OP_DRAW) |=> !in_ready)
    else $error("block still ready after a draw transfer");

  a_last_is_mem_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (kind == glcd_pkg::KIND_CMD && byte_value == glcd_pkg::CMD_MEM))
    else $error("last flag on a result other than the closing memory-write command");

  a_pix_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == glcd_pkg::KIND_PIX) |-> (!last && byte_value == 8'd0))
    else $error("pixel result carries a byte value or last flag");

  a_cmd_pixels_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != glcd_pkg::KIND_PIX) |-> (pixels == '0))
    else $error("command or parameter result carries pixel data");

endmodule
